/* rtl/sdof_exact_substructure_step_defines.svh */
// Assertion macros shared by the substructure step RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SDOF_EXACT_SUBSTRUCTURE_STEP_DEFINES_SVH
`define SDOF_EXACT_SUBSTRUCTURE_STEP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDOF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDOF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sdof_pkg.sv */
// Shared types and constants for the substructure step block.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package sdof_pkg;

  localparam int DATA_W      = 32;  // displacement, velocity and force fields
  localparam int COEF_W      = 32;  // one signed coefficient of a packed pair
  localparam int GAIN_W      = 31;  // stiffness, damping, damping per step
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 8;
  localparam int OPND_W      = 33;  // multiplier operand width
  localparam int PROD_W      = 2 * OPND_W;
  localparam int ACC_W       = 64;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_DISP_STATE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_DISP_FORCE = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_VEL_STATE  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_VEL_FORCE  = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_STIFFNESS       = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPING         = CFG_INDEX_W'(5);
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPING_PER_STEP = CFG_INDEX_W'(6);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S00, ST_S01, ST_S02, ST_S03, ST_S04, ST_S05, ST_S06, ST_S07, ST_S08,
    ST_S09, ST_S10, ST_S11, ST_S12, ST_S13, ST_S14, ST_S15, ST_S16, ST_S17
  } state_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [3:0] {
    MUL_KU,   // stiffness * input displacement
    MUL_VT,   // damping per step * displacement change
    MUL_A, MUL_B, MUL_C, MUL_D,
    MUL_E, MUL_F, MUL_G, MUL_H,
    MUL_KD,   // stiffness * (new mass displacement - input)
    MUL_CV    // damping * new velocity
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB_VT
  } acc_op_t;

  typedef enum logic [2:0] {
    CLAMP_NONE,
    CLAMP_FORCE,
    CLAMP_DISP,
    CLAMP_VEL,
    CLAMP_OUT
  } clamp_dest_t;

  typedef struct packed {
    logic        start;
    mul_op_t     mul_op;
    acc_op_t     acc_op;
    logic        vt_save;
    clamp_dest_t clamp_dest;
    logic        diff_en;
  } dp_cmd_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

endpackage

/* rtl/sdof_in_if.sv */
// Input channel: one imposed coupling displacement per transfer.
// Depends on sdof_pkg for the field width.
`timescale 1ns / 1ps

interface sdof_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sdof_pkg::DATA_W-1:0]   coupling_disp;

  modport source (output valid, output coupling_disp, input ready);
  modport sink   (input valid, input coupling_disp, output ready);
endinterface

/* rtl/sdof_out_if.sv */
// Result channel: coupling force and saturation flag per transfer.
// Depends on sdof_pkg for the field width.
`timescale 1ns / 1ps

interface sdof_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sdof_pkg::DATA_W-1:0]   coupling_force;
  logic                                 saturated;

  modport source (output valid, output coupling_force, output saturated, input ready);
  modport sink   (input valid, input coupling_force, input saturated, output ready);
endinterface

/* rtl/sdof_cfg_if.sv */
// Configuration write channel: register index and write data per transfer.
// Depends on sdof_pkg for the field widths.
`timescale 1ns / 1ps

interface sdof_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sdof_pkg::CFG_INDEX_W-1:0]    index;
  logic [sdof_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/sdof_dp.sv */
// Datapath: configuration registers, shared multiplier, rounding stage,
// saturating accumulator, clamp and state registers. Depends on sdof_pkg.
`timescale 1ns / 1ps

module sdof_dp #(
  parameter int DATA_WIDTH     = 32,
  parameter int FRAC_BITS      = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sdof_pkg::dp_cmd_t                    cmd,
  input  sdof_pkg::cfg_wr_t                    cfg_wr,
  input  logic signed [sdof_pkg::DATA_W-1:0]   in_disp,
  output logic signed [sdof_pkg::DATA_W-1:0]   out_force,
  output logic                                 out_sat
);

  localparam int DW  = sdof_pkg::DATA_W;
  localparam int CW  = sdof_pkg::COEF_W;
  localparam int GW  = sdof_pkg::GAIN_W;
  localparam int OW  = sdof_pkg::OPND_W;
  localparam int PW  = sdof_pkg::PROD_W;
  localparam int AW  = sdof_pkg::ACC_W;
  localparam int EFF_W = (DATA_WIDTH < DW) ? DATA_WIDTH : DW;

  localparam logic signed [AW-1:0] DATA_MAX = (AW'(1) << (EFF_W - 1)) - AW'(1);
  localparam logic signed [AW-1:0] DATA_MIN = ~DATA_MAX;
  localparam logic signed [AW-1:0] ACC_MAX  = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] ACC_MIN  = ~ACC_MAX;
  localparam logic signed [PW-1:0] HALF_DATA = (FRAC_BITS == 0) ? '0 :
      (PW'(1) << ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0));
  localparam logic signed [PW-1:0] HALF_COEF =
      PW'(1) << ((COEF_FRAC_BITS > 0) ? COEF_FRAC_BITS - 1 : 0);

  // Configuration registers.
  logic [2*CW-1:0] coef_ds_r, coef_df_r, coef_vs_r, coef_vf_r;
  logic [GW-1:0]   stiff_r, damp_r, dps_r;

  // Step state and per-step working registers.
  logic signed [DW-1:0] last_disp_r, last_force_r, mass_disp_r, mass_vel_r;
  logic signed [DW-1:0] u_r, f_new_r, d_new_r, v_new_r, out_force_r;
  logic signed [OW-1:0] du_r, diff_r;
  logic                 out_sat_r, flag_r;

  // Arithmetic pipeline.
  logic signed [OW-1:0] opa, opb;
  logic                 coef_sel;
  logic signed [PW-1:0] prod_r;
  logic                 prod_coef_r;
  logic signed [PW-1:0] rnd_half, rnd_sum, rnd_val;
  logic signed [AW-1:0] term_r, vterm_r, acc_r, acc_nxt, addend;
  logic signed [AW:0]   acc_sum;
  logic                 acc_ovf;
  logic signed [AW-1:0] clamped;
  logic                 clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_ds_r <= '0;
      coef_df_r <= '0;
      coef_vs_r <= '0;
      coef_vf_r <= '0;
      stiff_r   <= '0;
      damp_r    <= '0;
      dps_r     <= '0;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        sdof_pkg::REG_COEF_DISP_STATE:  coef_ds_r <= cfg_wr.data;
        sdof_pkg::REG_COEF_DISP_FORCE:  coef_df_r <= cfg_wr.data;
        sdof_pkg::REG_COEF_VEL_STATE:   coef_vs_r <= cfg_wr.data;
        sdof_pkg::REG_COEF_VEL_FORCE:   coef_vf_r <= cfg_wr.data;
        sdof_pkg::REG_STIFFNESS:        stiff_r   <= cfg_wr.data[GW-1:0];
        sdof_pkg::REG_DAMPING:          damp_r    <= cfg_wr.data[GW-1:0];
        sdof_pkg::REG_DAMPING_PER_STEP: dps_r     <= cfg_wr.data[GW-1:0];
        default: ;
      endcase
    end
  end

  // Operand selection: gains are zero-extended, coefficients and data sign-extended.
  always_comb begin
    opa      = '0;
    opb      = '0;
    coef_sel = 1'b0;
    unique case (cmd.mul_op)
      sdof_pkg::MUL_KU: begin
        opa = {2'b00, stiff_r};
        opb = {u_r[DW-1], u_r};
      end
      sdof_pkg::MUL_VT: begin
        opa = {2'b00, dps_r};
        opb = du_r;
      end
      sdof_pkg::MUL_A: begin
        opa = {coef_ds_r[2*CW-1], coef_ds_r[2*CW-1:CW]};
        opb = {mass_disp_r[DW-1], mass_disp_r};
        coef_sel = 1'b1;
      end
      sdof_pkg::MUL_B: begin
        opa = {coef_ds_r[CW-1], coef_ds_r[CW-1:0]};
        opb = {mass_vel_r[DW-1], mass_vel_r};
        coef_sel = 1'b1;
      end
      sdof_pkg::MUL_C: begin
        opa = {coef_df_r[2*CW-1], coef_df_r[2*CW-1:CW]};
        opb = {last_force_r[DW-1], last_force_r};
        coef_sel = 1'b1;
      end
      sdof_pkg::MUL_D: begin
        opa = {coef_df_r[CW-1], coef_df_r[CW-1:0]};
        opb = {f_new_r[DW-1], f_new_r};
        coef_sel = 1'b1;
      end
      sdof_pkg::MUL_E: begin
        opa = {coef_vs_r[2*CW-1], coef_vs_r[2*CW-1:CW]};
        opb = {mass_disp_r[DW-1], mass_disp_r};
        coef_sel = 1'b1;
      end
      sdof_pkg::MUL_F: begin
        opa = {coef_vs_r[CW-1], coef_vs_r[CW-1:0]};
        opb = {mass_vel_r[DW-1], mass_vel_r};
        coef_sel = 1'b1;
      end
      sdof_pkg::MUL_G: begin
        opa = {coef_vf_r[2*CW-1], coef_vf_r[2*CW-1:CW]};
        opb = {last_force_r[DW-1], last_force_r};
        coef_sel = 1'b1;
      end
      sdof_pkg::MUL_H: begin
        opa = {coef_vf_r[CW-1], coef_vf_r[CW-1:0]};
        opb = {f_new_r[DW-1], f_new_r};
        coef_sel = 1'b1;
      end
      sdof_pkg::MUL_KD: begin
        opa = {2'b00, stiff_r};
        opb = diff_r;
      end
      sdof_pkg::MUL_CV: begin
        opa = {2'b00, damp_r};
        opb = {v_new_r[DW-1], v_new_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r      <= opa * opb;
    prod_coef_r <= coef_sel;
    term_r      <= rnd_val[AW-1:0];
  end

  // Round half up: add half an LSB of the target format, then floor.
  always_comb begin
    rnd_half = prod_coef_r ? HALF_COEF : HALF_DATA;
    rnd_sum  = prod_r + rnd_half;
    rnd_val  = prod_coef_r ? (rnd_sum >>> COEF_FRAC_BITS) : (rnd_sum >>> FRAC_BITS);
  end

  // 64-bit saturating accumulate. The damping-rate term is never the most
  // negative 64-bit value, so its negation cannot wrap.
  always_comb begin
    addend  = (cmd.acc_op == sdof_pkg::ACC_SUB_VT) ? -vterm_r : term_r;
    acc_sum = {acc_r[AW-1], acc_r} + {addend[AW-1], addend};
    acc_ovf = 1'b0;
    acc_nxt = acc_r;
    case (cmd.acc_op) inside
      sdof_pkg::ACC_LOAD: acc_nxt = term_r;
      sdof_pkg::ACC_ADD, sdof_pkg::ACC_SUB_VT: begin
        if (acc_sum[AW] != acc_sum[AW-1]) begin
          acc_ovf = 1'b1;
          acc_nxt = acc_sum[AW] ? ACC_MIN : ACC_MAX;
        end else begin
          acc_nxt = acc_sum[AW-1:0];
        end
      end
      default: acc_nxt = acc_r;
    endcase
  end

  // Clamp the finished sum to the data range.
  always_comb begin
    clip    = 1'b0;
    clamped = acc_r;
    if (acc_r > DATA_MAX) begin
      clip    = 1'b1;
      clamped = DATA_MAX;
    end else if (acc_r < DATA_MIN) begin
      clip    = 1'b1;
      clamped = DATA_MIN;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.vt_save) begin
      vterm_r <= term_r;
    end
    if (cmd.start) begin
      u_r  <= in_disp;
      du_r <= {in_disp[DW-1], in_disp} - {last_disp_r[DW-1], last_disp_r};
    end
    if (cmd.diff_en) begin
      diff_r <= {d_new_r[DW-1], d_new_r} - {u_r[DW-1], u_r};
    end
    case (cmd.clamp_dest)
      sdof_pkg::CLAMP_FORCE: f_new_r <= clamped[DW-1:0];
      sdof_pkg::CLAMP_DISP:  d_new_r <= clamped[DW-1:0];
      sdof_pkg::CLAMP_VEL:   v_new_r <= clamped[DW-1:0];
      sdof_pkg::CLAMP_OUT: begin
        out_force_r <= clamped[DW-1:0];
        out_sat_r   <= flag_r | clip;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else if (cmd.start) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_r | acc_ovf | (clip && (cmd.clamp_dest != sdof_pkg::CLAMP_NONE));
    end
  end

  // Step state advances together with the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_disp_r  <= '0;
      last_force_r <= '0;
      mass_disp_r  <= '0;
      mass_vel_r   <= '0;
    end else if (cmd.clamp_dest == sdof_pkg::CLAMP_OUT) begin
      last_disp_r  <= u_r;
      last_force_r <= f_new_r;
      mass_disp_r  <= d_new_r;
      mass_vel_r   <= v_new_r;
    end
  end

  assign out_force = out_force_r;
  assign out_sat   = out_sat_r;

endmodule

/* rtl/sdof_ctrl.sv */
// Controller: fixed-schedule state machine that sequences the datapath
// and owns the channel handshakes. Depends on sdof_pkg and the defines header.
`timescale 1ns / 1ps
`include "sdof_exact_substructure_step_defines.svh"

module sdof_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sdof_pkg::dp_cmd_t cmd
);

  sdof_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == sdof_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      sdof_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sdof_pkg::ST_S00;
        end
      end
      [sdof_pkg::ST_S00:sdof_pkg::ST_S16]: begin
        state_nxt = sdof_pkg::state_t'(state_r + 5'd1);
      end
      sdof_pkg::ST_S17: begin
        if (slot_free) begin
          state_nxt = sdof_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sdof_pkg::ST_IDLE;
    endcase
  end

  // Each state names what every pipeline stage does in that cycle: multiplier
  // issue, accumulate (after the prod_r and term_r registers) and clamp.
  always_comb begin
    cmd            = '0;
    cmd.mul_op     = sdof_pkg::MUL_KU;
    cmd.acc_op     = sdof_pkg::ACC_HOLD;
    cmd.clamp_dest = sdof_pkg::CLAMP_NONE;
    unique case (state_r)
      sdof_pkg::ST_IDLE: cmd.start = in_valid;
      sdof_pkg::ST_S00:  cmd.mul_op = sdof_pkg::MUL_KU;
      sdof_pkg::ST_S01:  cmd.mul_op = sdof_pkg::MUL_VT;
      sdof_pkg::ST_S02: begin
        cmd.mul_op = sdof_pkg::MUL_A;
        cmd.acc_op = sdof_pkg::ACC_LOAD;
      end
      sdof_pkg::ST_S03: begin
        cmd.mul_op  = sdof_pkg::MUL_B;
        cmd.acc_op  = sdof_pkg::ACC_ADD;
        cmd.vt_save = 1'b1;
      end
      sdof_pkg::ST_S04: begin
        cmd.mul_op     = sdof_pkg::MUL_C;
        cmd.acc_op     = sdof_pkg::ACC_LOAD;
        cmd.clamp_dest = sdof_pkg::CLAMP_FORCE;
      end
      sdof_pkg::ST_S05: begin
        cmd.mul_op = sdof_pkg::MUL_D;
        cmd.acc_op = sdof_pkg::ACC_ADD;
      end
      sdof_pkg::ST_S06: begin
        cmd.mul_op = sdof_pkg::MUL_E;
        cmd.acc_op = sdof_pkg::ACC_ADD;
      end
      sdof_pkg::ST_S07: begin
        cmd.mul_op = sdof_pkg::MUL_F;
        cmd.acc_op = sdof_pkg::ACC_ADD;
      end
      sdof_pkg::ST_S08: begin
        cmd.mul_op     = sdof_pkg::MUL_G;
        cmd.acc_op     = sdof_pkg::ACC_LOAD;
        cmd.clamp_dest = sdof_pkg::CLAMP_DISP;
      end
      sdof_pkg::ST_S09: begin
        cmd.mul_op  = sdof_pkg::MUL_H;
        cmd.acc_op  = sdof_pkg::ACC_ADD;
        cmd.diff_en = 1'b1;
      end
      sdof_pkg::ST_S10: begin
        cmd.mul_op = sdof_pkg::MUL_KD;
        cmd.acc_op = sdof_pkg::ACC_ADD;
      end
      sdof_pkg::ST_S11: cmd.acc_op = sdof_pkg::ACC_ADD;
      sdof_pkg::ST_S12: begin
        cmd.acc_op     = sdof_pkg::ACC_LOAD;
        cmd.clamp_dest = sdof_pkg::CLAMP_VEL;
      end
      sdof_pkg::ST_S13: cmd.mul_op = sdof_pkg::MUL_CV;
      sdof_pkg::ST_S14: ;
      sdof_pkg::ST_S15: cmd.acc_op = sdof_pkg::ACC_ADD;
      sdof_pkg::ST_S16: cmd.acc_op = sdof_pkg::ACC_SUB_VT;
      sdof_pkg::ST_S17: begin
        if (slot_free) begin
          cmd.clamp_dest = sdof_pkg::CLAMP_OUT;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.clamp_dest == sdof_pkg::CLAMP_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdof_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SDOF_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == sdof_pkg::ST_S00, "accepted item did not start the schedule")
  `SDOF_ASSERT_NEXT(a_stall_holds, (state_r == sdof_pkg::ST_S17) && out_valid_r && !out_ready, (state_r == sdof_pkg::ST_S17) && out_valid_r, "finished step left while the output register was full")
  `SDOF_ASSERT_IMPL(a_load_slot_free, cmd.clamp_dest == sdof_pkg::CLAMP_OUT, !out_valid_r || out_ready, "result written over an untaken result")
  `SDOF_ASSERT_IMPL(a_valid_source, $rose(out_valid_r), $past(state_r) == sdof_pkg::ST_S17, "result became valid outside the final step")

endmodule

/* rtl/sdof_exact_substructure_step.sv */
// Top level of the damped single-degree-of-freedom substructure step.
// Depends on sdof_pkg, the three channel interfaces, sdof_ctrl and sdof_dp.
`timescale 1ns / 1ps

// Usage
// The block advances a damped mass-spring substructure by one time step for
// every transfer on in_chan, which carries the imposed coupling displacement.
// Each step produces exactly one transfer on out_chan with the coupling force
// and a flag that tells whether any intermediate or final value was clipped.
// The eight state-update coefficients and the three gains are written on
// cfg_chan, which is always ready; write them only while the block is idle.
// One step is the idle state that takes the input, then the schedule states
// ST_S00 to ST_S17, set by the twelve products that go one per cycle through the
// single shared 33 x 33 multiplier and its rounding and accumulate stages, plus
// the clamp steps that the force, displacement and velocity results wait on.
// A new input is taken as soon as the schedule returns to idle, even while
// the previous result still waits in the output register. When the receiver
// stalls and a result is still waiting, the next step holds in its last cycle
// until the output register frees up. Synchronous active-low reset clears the
// configuration registers and the mass state to zero and drops out_chan.valid.
module sdof_exact_substructure_step #(
  parameter int DATA_WIDTH     = 32,
  parameter int FRAC_BITS      = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  sdof_in_if.sink     in_chan,
  sdof_out_if.source  out_chan,
  sdof_cfg_if.sink    cfg_chan
);

  sdof_pkg::dp_cmd_t cmd;
  sdof_pkg::cfg_wr_t cfg_wr;

  // Configuration writes never stall; the datapath decodes the index.
  assign cfg_chan.ready = 1'b1;
  assign cfg_wr.we      = cfg_chan.valid;
  assign cfg_wr.index   = cfg_chan.index;
  assign cfg_wr.data    = cfg_chan.data;

  // The controller owns both handshakes and the fixed step schedule.
  sdof_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // The datapath holds the registers, the shared multiplier and the result.
  sdof_dp #(
    .DATA_WIDTH     (DATA_WIDTH),
    .FRAC_BITS      (FRAC_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_wr    (cfg_wr),
    .in_disp   (in_chan.coupling_disp),
    .out_force (out_chan.coupling_force),
    .out_sat   (out_chan.saturated)
  );

endmodule

/* tb/sv/sdof_step_scoreboard_pkg.sv */
// Scoreboard for the substructure step block: a bit-exact predictor of the coupling force
// and a queue of expected results, checked in order. Depends on sdof_pkg for widths and
// register indexes.
`timescale 1ns / 1ps

package sdof_step_check_pkg;

  typedef struct packed {
    logic signed [sdof_pkg::DATA_W-1:0] coupling_force;
    logic                               saturated;
  } force_result_t;

  class sdof_step_scoreboard #(
    int DATA_WIDTH     = 32,
    int FRAC_BITS      = 16,
    int COEF_FRAC_BITS = 24
  );
    localparam int     EFF_W   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;

    logic [sdof_pkg::CFG_DATA_W-1:0] disp_state_pair, disp_force_pair;
    logic [sdof_pkg::CFG_DATA_W-1:0] vel_state_pair, vel_force_pair;
    logic [sdof_pkg::GAIN_W-1:0]     stiffness, damping, damping_per_step;
    longint                          last_disp, last_force, mass_disp, mass_vel;
    bit                              clipped;
    force_result_t                   expected_forces[$];
    int                              mismatch_count;

    function new();
      disp_state_pair  = '0;
      disp_force_pair  = '0;
      vel_state_pair   = '0;
      vel_force_pair   = '0;
      stiffness        = '0;
      damping          = '0;
      damping_per_step = '0;
      last_disp        = 0;
      last_force       = 0;
      mass_disp        = 0;
      mass_vel         = 0;
      mismatch_count   = 0;
    endfunction

    // Mirrors a configuration transfer; unknown indexes leave everything as it was.
    function void write_reg(logic [sdof_pkg::CFG_INDEX_W-1:0] index,
                            logic [sdof_pkg::CFG_DATA_W-1:0] value);
      case (index)
        sdof_pkg::REG_COEF_DISP_STATE:  disp_state_pair  = value;
        sdof_pkg::REG_COEF_DISP_FORCE:  disp_force_pair  = value;
        sdof_pkg::REG_COEF_VEL_STATE:   vel_state_pair   = value;
        sdof_pkg::REG_COEF_VEL_FORCE:   vel_force_pair   = value;
        sdof_pkg::REG_STIFFNESS:        stiffness        = value[sdof_pkg::GAIN_W-1:0];
        sdof_pkg::REG_DAMPING:          damping          = value[sdof_pkg::GAIN_W-1:0];
        sdof_pkg::REG_DAMPING_PER_STEP: damping_per_step = value[sdof_pkg::GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // Round half up: add half an LSB, then an arithmetic shift takes the floor.
    function longint round_shift(longint x, int unsigned s);
      if (s == 0) return x;
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
        clipped = 1'b1;
        return a[63] ? ACC_MIN : ACC_MAX;
      end
      return s;
    endfunction

    function longint clamp_data(longint x);
      longint hi;
      longint lo;
      hi = (longint'(1) << (EFF_W - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) begin
        clipped = 1'b1;
        return hi;
      end
      if (x < lo) begin
        clipped = 1'b1;
        return lo;
      end
      return x;
    endfunction

    function longint coef_mul(logic [31:0] coef, longint v);
      longint c;
      c = $signed(coef);
      return round_shift(c * v, COEF_FRAC_BITS);
    endfunction

    // Advances the mass state by one step and queues the coupling force it yields.
    function void note_disp(logic signed [sdof_pkg::DATA_W-1:0] coupling_disp);
      longint        u, du, k, c, cps, vterm, f_old, f_new, d_new, v_new, acc, fc;
      force_result_t r;
      clipped = 1'b0;
      u     = coupling_disp;
      du    = u - last_disp;
      k     = longint'(stiffness);
      c     = longint'(damping);
      cps   = longint'(damping_per_step);
      vterm = round_shift(cps * du, FRAC_BITS);
      f_old = last_force;

      acc   = sat_add(round_shift(k * u, FRAC_BITS), vterm);
      f_new = clamp_data(acc);

      acc   = coef_mul(disp_state_pair[63:32], mass_disp);
      acc   = sat_add(acc, coef_mul(disp_state_pair[31:0], mass_vel));
      acc   = sat_add(acc, coef_mul(disp_force_pair[63:32], f_old));
      acc   = sat_add(acc, coef_mul(disp_force_pair[31:0], f_new));
      d_new = clamp_data(acc);

      acc   = coef_mul(vel_state_pair[63:32], mass_disp);
      acc   = sat_add(acc, coef_mul(vel_state_pair[31:0], mass_vel));
      acc   = sat_add(acc, coef_mul(vel_force_pair[63:32], f_old));
      acc   = sat_add(acc, coef_mul(vel_force_pair[31:0], f_new));
      v_new = clamp_data(acc);

      acc   = round_shift(k * (d_new - u), FRAC_BITS);
      acc   = sat_add(acc, round_shift(c * v_new, FRAC_BITS));
      acc   = sat_add(acc, -vterm);
      fc    = clamp_data(acc);

      last_disp  = u;
      last_force = f_new;
      mass_disp  = d_new;
      mass_vel   = v_new;

      r.coupling_force = fc[sdof_pkg::DATA_W-1:0];
      r.saturated      = clipped;
      expected_forces.push_back(r);
    endfunction

    function void check_force(logic signed [sdof_pkg::DATA_W-1:0] coupling_force,
                              logic saturated);
      force_result_t want;
      if (expected_forces.size() == 0) begin
        $error("unexpected result transfer: coupling_force %0d, saturated %0b",
               coupling_force, saturated);
        mismatch_count++;
        return;
      end
      want = expected_forces.pop_front();
      if (coupling_force !== want.coupling_force) begin
        $error("coupling_force: expected %0d, actual %0d", want.coupling_force, coupling_force);
        mismatch_count++;
      end
      if (saturated !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, saturated);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return expected_forces.size();
    endfunction
  endclass

endpackage

/* tb/sv/tb_top.sv */
// Top-level testbench for sdof_exact_substructure_step: drives displacements and register
// writes, takes coupling forces under random back-pressure and checks them in order.
// Depends on sdof_pkg, the three channel interfaces, the block and sdof_step_check_pkg.
`timescale 1ns / 1ps

module tb_top;

  localparam int DATA_WIDTH       = 32;
  localparam int FRAC_BITS        = 16;
  localparam int COEF_FRAC_BITS   = 24;
  localparam int SENDER_IDLE_PCT  = 59;
  localparam int RECV_STALL_PCT   = 59;
  localparam int BOTH_IDLE_PCT    = 17;
  localparam int LONG_HOLD_CYCLES = 300;
  // Longer than one unstalled step of the block, which is plenty to catch a stray extra
  // result at the end of the run.
  localparam int SETTLE_CYCLES    = 60;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  sdof_in_if  in_if();
  sdof_out_if out_if();
  sdof_cfg_if cfg_if();

  sdof_exact_substructure_step #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRAC_BITS     (FRAC_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  sdof_step_check_pkg::sdof_step_scoreboard #(DATA_WIDTH, FRAC_BITS, COEF_FRAC_BITS) sb =
      new();

  // Idle behavior of the two sides. The stimulus process sets these; the result
  // process reads the stall rate and clears the long-hold request when it takes it.
  int                 sender_idle_pct    = 0;
  int                 receiver_stall_pct = 0;
  bit                 long_hold_req      = 1'b0;
  logic signed [31:0] walk_disp          = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic set_idle_mode(idle_mode_t mode);
    sender_idle_pct    = (mode == IDLE_SENDER)   ? SENDER_IDLE_PCT :
                         (mode == IDLE_BOTH)     ? BOTH_IDLE_PCT : 0;
    receiver_stall_pct = (mode == IDLE_RECEIVER) ? RECV_STALL_PCT :
                         (mode == IDLE_BOTH)     ? BOTH_IDLE_PCT : 0;
  endtask

  // One configuration transfer. Valid is left high so that back-to-back writes
  // never lower and raise it within one time step; the caller drops it at the end.
  task automatic write_cfg(logic [sdof_pkg::CFG_INDEX_W-1:0] index,
                           logic [sdof_pkg::CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(index, value);
  endtask

  // Gains are 31 bits wide; the upper register bits are filled with noise, which
  // the block has to drop.
  function automatic logic [63:0] gain_word(logic [30:0] gain);
    logic [63:0] w;
    w       = {$urandom, $urandom};
    w[30:0] = gain;
    return w;
  endfunction

  // Writes the full register set, then a write to an index past the last register,
  // which the block must ignore. Called only when no result is outstanding.
  task automatic program_regs(logic [63:0] disp_state, logic [63:0] disp_force,
                              logic [63:0] vel_state, logic [63:0] vel_force,
                              logic [30:0] k, logic [30:0] c, logic [30:0] c_per_step);
    write_cfg(sdof_pkg::REG_COEF_DISP_STATE, disp_state);
    write_cfg(sdof_pkg::REG_COEF_DISP_FORCE, disp_force);
    write_cfg(sdof_pkg::REG_COEF_VEL_STATE, vel_state);
    write_cfg(sdof_pkg::REG_COEF_VEL_FORCE, vel_force);
    write_cfg(sdof_pkg::REG_STIFFNESS, gain_word(k));
    write_cfg(sdof_pkg::REG_DAMPING, gain_word(c));
    write_cfg(sdof_pkg::REG_DAMPING_PER_STEP, gain_word(c_per_step));
    write_cfg(8'($urandom_range(255, int'(sdof_pkg::REG_DAMPING_PER_STEP) + 1)),
              {$urandom, $urandom});
    cfg_if.valid <= 1'b0;
  endtask

  // Offers one displacement and waits for its transfer. An idle gap, if any, comes
  // before the item, so valid is only lowered in a step where nothing raises it.
  // Now and then a long gap is drawn so that idle time lands on every stage of the
  // block's schedule, not only inside its busy window.
  task automatic send_disp(logic signed [31:0] u);
    int gap;
    gap = 0;
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < 10) begin
      gap = $urandom_range(1, 40);
    end else begin
      while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.coupling_disp <= u;
    do @(posedge clk); while (!in_if.ready);
    sb.note_disp(u);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // A random walk in 45% of draws, as a real coupling displacement moves, mixed
  // with independent small values, full-range values and the field extremes.
  function automatic logic signed [31:0] next_disp();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      walk_disp = walk_disp + ($signed($urandom) >>> $urandom_range(10, 26));
    end else if (pick < 75) begin
      walk_disp = $signed($urandom) >>> $urandom_range(4, 24);
    end else if (pick < 92) begin
      walk_disp = $urandom;
    end else begin
      case ($urandom_range(0, 4))
        0:       walk_disp = 32'sh7FFF_FFFF;
        1:       walk_disp = 32'sh8000_0000;
        2:       walk_disp = 32'sh0000_0000;
        3:       walk_disp = 32'sh0000_0001;
        default: walk_disp = -32'sd1;
      endcase
    end
    return walk_disp;
  endfunction

  // A coefficient with a random magnitude, so that some settings stay in range for
  // many steps and others saturate at once.
  function automatic logic [31:0] rand_coef();
    return $signed($urandom) >>> $urandom_range(4, 31);
  endfunction

  function automatic logic [30:0] rand_gain();
    return 31'($urandom >> $urandom_range(1, 28));
  endfunction

  task automatic run_phase(idle_mode_t mode, int n_items);
    set_idle_mode(mode);
    repeat (n_items) send_disp(next_disp());
    in_if.valid <= 1'b0;
    wait_drained();
  endtask

  // Result side: checks each transfer against the oldest prediction and draws the
  // next cycle's ready. A long hold, once requested, keeps ready low long enough
  // for the block to fill up and stall its input.
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        sb.check_force(out_if.coupling_force, out_if.saturated);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // Stimulus: a short directed burst and random phases under a plausible, lightly damped
  // setting, then coefficient and gain extremes, -1 LSB coefficients with zero gains,
  // all-zero and random settings. Registers change only once every result is back.
  initial begin
    logic signed [31:0] directed_disps[$];
    directed_disps = '{
      32'sh0000_0000, 32'sh0000_0001, -32'sd1, 32'sh0001_0000, -32'sh0001_0000,
      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
      32'sh0000_0000, 32'sh4000_0000, -32'sh4000_0000, 32'sh0000_8000, 32'sh0000_7FFF,
      32'sh0010_0000, 32'sh0020_0000, 32'sh0030_0000, 32'sh0020_0000, 32'sh0000_0000
    };

    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.coupling_disp <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= '0;
    cfg_if.data         <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Lightly damped oscillator in Q8.24 coefficients: A 0.95, B 0.01, C and D 0.001,
    // E -0.5, F 0.9, G and H 0.01; stiffness 2.0, damping 0.05, damping per step 0.5.
    program_regs({32'h00F3_3333, 32'h0002_8F5C}, {32'h0000_4189, 32'h0000_4189},
                 {32'hFF80_0000, 32'h00E6_6666}, {32'h0002_8F5C, 32'h0002_8F5C},
                 31'h0002_0000, 31'h0000_0CCD, 31'h0000_8000);

    // Directed burst: field extremes, unit steps and the large jumps that make the
    // force, the mass state and the output saturate.
    set_idle_mode(IDLE_NONE);
    foreach (directed_disps[i]) send_disp(directed_disps[i]);
    in_if.valid <= 1'b0;
    wait_drained();

    run_phase(IDLE_SENDER, 80);

    // Receiver-stall phase with both kinds of pressure: a long hold early on while
    // the sender keeps offering, and later a full drain before going on.
    set_idle_mode(IDLE_RECEIVER);
    for (int i = 0; i < 80; i++) begin
      if (i == 10) long_hold_req = 1'b1;
      if (i == 50) begin
        in_if.valid <= 1'b0;
        wait_drained();
      end
      send_disp(next_disp());
    end
    in_if.valid <= 1'b0;
    wait_drained();

    // Largest positive coefficients and gains.
    program_regs({32'h7FFF_FFFF, 32'h7FFF_FFFF}, {32'h7FFF_FFFF, 32'h7FFF_FFFF},
                 {32'h7FFF_FFFF, 32'h7FFF_FFFF}, {32'h7FFF_FFFF, 32'h7FFF_FFFF},
                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    run_phase(IDLE_BOTH, 40);

    // Most negative coefficients with the largest gains.
    program_regs({32'h8000_0000, 32'h8000_0000}, {32'h8000_0000, 32'h8000_0000},
                 {32'h8000_0000, 32'h8000_0000}, {32'h8000_0000, 32'h8000_0000},
                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    run_phase(IDLE_NONE, 40);

    // Coefficients of minus one LSB with zero gains, then everything zero.
    program_regs({32'hFFFF_FFFF, 32'hFFFF_FFFF}, {32'hFFFF_FFFF, 32'hFFFF_FFFF},
                 {32'hFFFF_FFFF, 32'hFFFF_FFFF}, {32'hFFFF_FFFF, 32'hFFFF_FFFF},
                 31'h0, 31'h0, 31'h0);
    run_phase(IDLE_RECEIVER, 20);
    program_regs('0, '0, '0, '0, 31'h0, 31'h0, 31'h0);
    run_phase(IDLE_SENDER, 20);

    // Random settings; the first uses raw 64-bit words, the rest scaled values.
    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, 31'($urandom), 31'($urandom), 31'($urandom));
      end else begin
        program_regs({rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                     {rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                     rand_gain(), rand_gain(), rand_gain());
      end
      run_phase(idle_mode_t'(p % 4), 42);
    end

    // Every prediction is matched; give a stray extra result time to show up.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("** sdof_exact_substructure_step: PASSED **");
    end else begin
      $display("** sdof_exact_substructure_step: FAILED **");
    end
    $finish;
  end

  // Watchdog: a correct run ends far sooner, even with every stall at its longest.
  initial begin
    #1_000_000;
    $display("** sdof_exact_substructure_step: FAILED **");
    $finish;
  end

endmodule
